/* hw/rtl/ssfi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfi_pkg: shared types and constants of the surface flux integral
// Grid limits, configuration register indexes, mode codes and the classified
// node item that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package ssfi_pkg;

  // Grid limits
  localparam int MAX_COLUMNS = 4096;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int COLS_REG_W  = 13;
  localparam int ROWS_REG_W  = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Front-to-back item queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Field widths
  localparam int WEIGHT_W = 17;
  localparam int COMP_W   = 32;
  localparam int RESULT_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 2'd0,
    CFG_COLUMNS = 2'd1,
    CFG_ROWS    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    MODE_CELL = 1'b0,
    MODE_NODE = 1'b1
  } mode_e;

  // One node, classified by its place in the grid
  typedef struct packed {
    mode_e                     mode;
    logic                      use_cell;  // node closes a cell (row >= 1, column >= 1)
    logic                      last;      // final node of the grid
    logic [COL_W-1:0]          addr;      // column, line buffer address
    logic [WEIGHT_W-1:0]       weight;
    logic signed [COMP_W-1:0]  vec_x;
    logic signed [COMP_W-1:0]  vec_y;
    logic signed [COMP_W-1:0]  vec_z;
    logic signed [COMP_W-1:0]  normal_x;
    logic signed [COMP_W-1:0]  normal_y;
    logic signed [COMP_W-1:0]  normal_z;
  } item_t;

endpackage

/* hw/rtl/structured_surface_flux_integral.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// structured_surface_flux_integral: streaming surface flux over a grid
// Node items in raster order in, one Q48.16 integral per grid out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the node fields with push_i high; an item is taken
//   on a clock edge where push_i is high and full_o is low.
//   Result channel: while empty_o is low, integral_o and overflowed_o hold
//   the oldest result; pop_i high on a clock edge takes it.
//   Config channel: cfg_ready_o is always high; index 0 mode, 1 columns,
//   2 rows. Any write to these restarts the grid. Write only while idle.
//   Back end: each item runs through one shared registered multiplier; a new
//   item is taken only from idle, and a cell-mode node that closes a cell
//   takes the longest. A four-item queue decouples input.
//   Result: the final node's accumulate state writes the result register
//   when no earlier result is waiting.
//   Reset: counters, accumulator and queue clear at once; registers return to
//   cell mode, 2 by 2 grid. The line buffer needs no clearing.
//   Receiver stall: a waiting result does not block input until the next
//   grid's final node is ready to publish; then the back end waits for pop.
// ----------------------------------------------------------------------------
module structured_surface_flux_integral import ssfi_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [WEIGHT_W-1:0]          weight_i,
  input  logic signed [COMP_W-1:0]     vec_x_i,
  input  logic signed [COMP_W-1:0]     vec_y_i,
  input  logic signed [COMP_W-1:0]     vec_z_i,
  input  logic signed [COMP_W-1:0]     normal_x_i,
  input  logic signed [COMP_W-1:0]     normal_y_i,
  input  logic signed [COMP_W-1:0]     normal_z_i,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic signed [RESULT_W-1:0]   integral_o,
  output logic                         overflowed_o
);

  logic   q_push;
  logic   q_pop;
  logic   q_empty;
  logic   clear;
  item_t  q_in;
  item_t  q_out;

  // front end: registers and node classification
  ssfi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push_i),
    .weight_i    (weight_i),
    .vec_x_i     (vec_x_i),
    .vec_y_i     (vec_y_i),
    .vec_z_i     (vec_z_i),
    .normal_x_i  (normal_x_i),
    .normal_y_i  (normal_y_i),
    .normal_z_i  (normal_z_i),
    .q_full_i    (full_o),
    .q_push_o    (q_push),
    .q_item_o    (q_in),
    .clear_o     (clear)
  );

  // decoupling queue
  ssfi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (full_o),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_out)
  );

  // back end: arithmetic, line buffer, accumulator, result
  ssfi_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (clear),
    .q_empty_i    (q_empty),
    .q_item_i     (q_out),
    .q_pop_o      (q_pop),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .integral_o   (integral_o),
    .overflowed_o (overflowed_o)
  );

endmodule

/* hw/rtl/ssfi_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfi_front: configuration registers and node classification
// Holds mode, columns and rows, tracks the raster position of each accepted
// node and tags it with its cell role and end-of-grid flag for the back end.
// ----------------------------------------------------------------------------
module ssfi_front import ssfi_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  // node input
  input  logic                        push_i,
  input  logic [WEIGHT_W-1:0]         weight_i,
  input  logic signed [COMP_W-1:0]    vec_x_i,
  input  logic signed [COMP_W-1:0]    vec_y_i,
  input  logic signed [COMP_W-1:0]    vec_z_i,
  input  logic signed [COMP_W-1:0]    normal_x_i,
  input  logic signed [COMP_W-1:0]    normal_y_i,
  input  logic signed [COMP_W-1:0]    normal_z_i,
  // queue towards the back end
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output item_t                       q_item_o,
  // grid abandoned by a register write
  output logic                        clear_o
);

  mode_e                   mode_q;
  logic [COLS_REG_W-1:0]   columns_q;
  logic [ROWS_REG_W-1:0]   rows_q;
  logic [COL_W-1:0]        col_q;
  logic [ROWS_REG_W-1:0]   row_q;

  logic                    cfg_we;
  logic                    cfg_hit;
  logic                    accept;
  logic [COLS_REG_W-1:0]   cols_m1;
  logic [COL_W-1:0]        ncol_m1;
  logic [ROWS_REG_W-1:0]   nrow_m1;
  logic                    col_last;
  logic                    row_last;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign accept      = push_i & ~q_full_i;

  // only a write to a known register abandons the grid
  always_comb begin
    case (cfg_index_i)
      CFG_MODE, CFG_COLUMNS, CFG_ROWS: cfg_hit = 1'b1;
      default:                         cfg_hit = 1'b0;
    endcase
  end
  assign clear_o = cfg_we & cfg_hit;

  // effective grid size, zero read as one, columns clamped to the buffer
  assign cols_m1 = columns_q - COLS_REG_W'(1);
  always_comb begin
    if (columns_q == '0) begin
      ncol_m1 = '0;
    end else if (columns_q > COLS_REG_W'(MAX_COLUMNS)) begin
      ncol_m1 = COL_W'(MAX_COLUMNS - 1);
    end else begin
      ncol_m1 = cols_m1[COL_W-1:0];
    end
  end
  assign nrow_m1 = (rows_q == '0) ? '0 : rows_q - ROWS_REG_W'(1);

  assign col_last = (col_q == ncol_m1);
  assign row_last = (row_q == nrow_m1);

  // classified item
  always_comb begin
    q_item_o.mode     = mode_q;
    q_item_o.use_cell = (row_q != '0) && (col_q != '0);
    q_item_o.last     = col_last & row_last;
    q_item_o.addr     = col_q;
    q_item_o.weight   = weight_i;
    q_item_o.vec_x    = vec_x_i;
    q_item_o.vec_y    = vec_y_i;
    q_item_o.vec_z    = vec_z_i;
    q_item_o.normal_x = normal_x_i;
    q_item_o.normal_y = normal_y_i;
    q_item_o.normal_z = normal_z_i;
  end
  assign q_push_o = accept;

  // registers and raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_CELL;
      columns_q <= COLS_REG_W'(2);
      rows_q    <= ROWS_REG_W'(2);
      col_q     <= '0;
      row_q     <= '0;
    end else if (clear_o) begin
      case (cfg_index_i)
        CFG_MODE:    mode_q    <= mode_e'(cfg_data_i[0]);
        CFG_COLUMNS: columns_q <= cfg_data_i[COLS_REG_W-1:0];
        CFG_ROWS:    rows_q    <= cfg_data_i[ROWS_REG_W-1:0];
        default:     ;
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_last ? '0 : row_q + ROWS_REG_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/ssfi_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfi_queue: short item queue between front end and back end
// Small synchronous FIFO of classified items; lets either side stall alone.
// ----------------------------------------------------------------------------
module ssfi_queue import ssfi_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  item_t  item_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output item_t  item_o
);

  item_t               entry_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = entry_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* hw/rtl/ssfi_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfi_back: arithmetic sequencer, line buffer and accumulator
// Runs each item through one shared registered multiplier, keeps the previous
// row of weighted vectors, accumulates with saturation and holds the result.
// ----------------------------------------------------------------------------
module ssfi_back import ssfi_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clear_i,
  // item queue
  input  logic                         q_empty_i,
  input  item_t                        q_item_i,
  output logic                         q_pop_o,
  // result channel
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic signed [RESULT_W-1:0]   integral_o,
  output logic                         overflowed_o
);

  localparam int MA_W = 34;            // multiplier operand A
  localparam int MB_W = 33;            // multiplier operand B
  localparam int P_W  = MA_W + MB_W;   // product
  localparam int T_W  = 52;            // per-item term
  localparam int D_W  = 50;            // node-mode dot product
  localparam int LB_W = 3 * COMP_W;    // line buffer word

  typedef enum logic [4:0] {
    ST_IDLE, ST_W0, ST_W1, ST_W2, ST_W3, ST_SUM,
    ST_F0, ST_F1, ST_F2, ST_F3,
    ST_N0, ST_N1, ST_N2, ST_N3, ST_D0, ST_D1, ST_D2,
    ST_ACC
  } state_e;

  state_e                      state_q;
  item_t                       it_q;
  logic signed [P_W-1:0]       p_q;
  logic signed [MA_W-1:0]      mul_a;
  logic signed [MB_W-1:0]      mul_b;
  logic signed [COMP_W-1:0]    cur_q  [3];
  logic signed [COMP_W-1:0]    left_q [3];
  logic signed [COMP_W-1:0]    ul_q   [3];
  logic signed [MA_W-1:0]      f_q    [3];
  logic signed [T_W-1:0]       t_q;
  logic signed [D_W-1:0]       d_q;
  logic [LB_W-1:0]             row_store_q [MAX_COLUMNS];
  logic [LB_W-1:0]             rd_q;
  logic signed [COMP_W-1:0]    up   [3];
  logic signed [T_W-1:0]       p_term;
  logic signed [COMP_W-1:0]    p_sat;
  logic signed [RESULT_W-1:0]  acc_q;
  logic                        sat_q;
  logic signed [RESULT_W:0]    sum;
  logic                        sum_ovf;
  logic signed [RESULT_W-1:0]  acc_new;
  logic                        res_valid_q;

  // floor(x / 2^16) of a product, saturated to 32 bits
  function automatic logic signed [COMP_W-1:0] sat32(input logic [P_W-17:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[P_W-17:COMP_W-1];
    hi_zeros = ~|v[P_W-17:COMP_W-1];
    if (hi_ones || hi_zeros) begin
      return v[COMP_W-1:0];
    end else if (v[P_W-17]) begin
      return {1'b1, {(COMP_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COMP_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [MA_W-1:0] sx34(input logic [COMP_W-1:0] v);
    return {{(MA_W-COMP_W){v[COMP_W-1]}}, v};
  endfunction

  assign up[0] = rd_q[LB_W-1:2*COMP_W];
  assign up[1] = rd_q[2*COMP_W-1:COMP_W];
  assign up[2] = rd_q[COMP_W-1:0];

  // product shifted right 16, floor rounding
  assign p_term = {p_q[P_W-1], p_q[P_W-1:16]};
  assign p_sat  = sat32(p_q[P_W-1:16]);

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      ST_W0:   begin mul_a = sx34(it_q.vec_x); mul_b = MB_W'(it_q.weight); end
      ST_W1:   begin mul_a = sx34(it_q.vec_y); mul_b = MB_W'(it_q.weight); end
      ST_W2:   begin mul_a = sx34(it_q.vec_z); mul_b = MB_W'(it_q.weight); end
      ST_F0:   begin mul_a = f_q[0]; mul_b = {it_q.normal_x[COMP_W-1], it_q.normal_x}; end
      ST_F1:   begin mul_a = f_q[1]; mul_b = {it_q.normal_y[COMP_W-1], it_q.normal_y}; end
      ST_F2:   begin mul_a = f_q[2]; mul_b = {it_q.normal_z[COMP_W-1], it_q.normal_z}; end
      ST_N0:   begin mul_a = sx34(it_q.normal_x); mul_b = {it_q.vec_x[COMP_W-1], it_q.vec_x}; end
      ST_N1:   begin mul_a = sx34(it_q.normal_y); mul_b = {it_q.vec_y[COMP_W-1], it_q.vec_y}; end
      ST_N2:   begin mul_a = sx34(it_q.normal_z); mul_b = {it_q.vec_z[COMP_W-1], it_q.vec_z}; end
      // node weight applied to the dot product in two halves
      ST_D0:   begin mul_a = d_q[D_W-1:16]; mul_b = MB_W'(it_q.weight); end
      ST_D1:   begin mul_a = {{(MA_W-16){1'b0}}, d_q[15:0]}; mul_b = MB_W'(it_q.weight); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // saturating accumulate
  assign sum     = {acc_q[RESULT_W-1], acc_q} + {{(RESULT_W+1-T_W){t_q[T_W-1]}}, t_q};
  assign sum_ovf = sum[RESULT_W] ^ sum[RESULT_W-1];
  always_comb begin
    if (!sum_ovf) begin
      acc_new = sum[RESULT_W-1:0];
    end else if (sum[RESULT_W]) begin
      acc_new = {1'b1, {(RESULT_W-1){1'b0}}};
    end else begin
      acc_new = {1'b0, {(RESULT_W-1){1'b1}}};
    end
  end

  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i;
  assign empty_o = ~res_valid_q;

  // sequencer, accumulator and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      acc_q        <= '0;
      sat_q        <= 1'b0;
      res_valid_q  <= 1'b0;
      integral_o   <= '0;
      overflowed_o <= 1'b0;
    end else begin
      if (pop_i && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            state_q <= (q_item_i.mode == MODE_CELL) ? ST_W0 : ST_N0;
          end
        end
        ST_W0:  state_q <= ST_W1;
        ST_W1:  state_q <= ST_W2;
        ST_W2:  state_q <= ST_W3;
        ST_W3:  state_q <= ST_SUM;
        ST_SUM: state_q <= it_q.use_cell ? ST_F0 : ST_ACC;
        ST_F0:  state_q <= ST_F1;
        ST_F1:  state_q <= ST_F2;
        ST_F2:  state_q <= ST_F3;
        ST_F3:  state_q <= ST_ACC;
        ST_N0:  state_q <= ST_N1;
        ST_N1:  state_q <= ST_N2;
        ST_N2:  state_q <= ST_N3;
        ST_N3:  state_q <= ST_D0;
        ST_D0:  state_q <= ST_D1;
        ST_D1:  state_q <= ST_D2;
        ST_D2:  state_q <= ST_ACC;
        ST_ACC: begin
          if (!it_q.last) begin
            acc_q   <= acc_new;
            sat_q   <= sat_q | sum_ovf;
            state_q <= ST_IDLE;
          end else if (!res_valid_q) begin
            // end of grid: publish and start the next grid clean
            res_valid_q  <= 1'b1;
            overflowed_o <= sat_q | sum_ovf;
            integral_o   <= (it_q.mode == MODE_CELL) ?
                            {{2{acc_new[RESULT_W-1]}}, acc_new[RESULT_W-1:2]} : acc_new;
            acc_q        <= '0;
            sat_q        <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (clear_i) begin
        acc_q <= '0;
        sat_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          it_q <= q_item_i;
        end
      end
      ST_W1: cur_q[0] <= p_sat;
      ST_W2: cur_q[1] <= p_sat;
      ST_W3: cur_q[2] <= p_sat;
      ST_SUM: begin
        for (int k = 0; k < 3; k++) begin
          f_q[k]    <= sx34(ul_q[k]) + sx34(up[k]) + sx34(left_q[k]) + sx34(cur_q[k]);
          left_q[k] <= cur_q[k];
          ul_q[k]   <= up[k];
        end
        t_q <= '0;
      end
      ST_F1: t_q <= p_term;
      ST_F2: t_q <= t_q + p_term;
      ST_F3: t_q <= t_q + p_term;
      ST_N1: d_q <= p_q[D_W+15:16];
      ST_N2: d_q <= d_q + p_q[D_W+15:16];
      ST_N3: d_q <= d_q + p_q[D_W+15:16];
      ST_D1: t_q <= p_q[T_W-1:0];
      ST_D2: t_q <= t_q + p_term;
      default: ;
    endcase
  end

  // line buffer of the previous row's weighted vectors
  always_ff @(posedge clk_i) begin
    if (state_q == ST_W0) begin
      rd_q <= row_store_q[it_q.addr];
    end
    if (state_q == ST_W3) begin
      row_store_q[it_q.addr] <= {cur_q[0], cur_q[1], p_sat};
    end
  end

endmodule

/* hw/rtl/ssfi_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfi_checker: port-level checks of the surface flux integral
// Watches the item and result channels of the top level over time.
// ----------------------------------------------------------------------------
module ssfi_checker import ssfi_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic                        full_o,
  input  logic                        pop_i,
  input  logic                        empty_o,
  input  logic signed [RESULT_W-1:0]  integral_o,
  input  logic                        overflowed_o
);

  // no result survives reset
  assert property (@(posedge clk_i) !rst_ni |=> empty_o)
    else $error("result shown after reset");

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(integral_o) && $stable(overflowed_o)))
    else $error("waiting result changed before pop");

  // the queue fills only when an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !full_o) |=> !$rose(full_o))
    else $error("full rose without an accepted item");

  // a taken result is never replaced in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !empty_o) |=> empty_o)
    else $error("new result published on the pop edge");

endmodule

bind structured_surface_flux_integral ssfi_checker u_checker (.*);
